/* rtl/core/dwrpi_pkg.sv */
// Shared types and constants for the dual wheel ramped PI controller.
`timescale 1ns / 1ps

package dwrpi_pkg;

    // Field widths
    localparam int VEL_W   = 16;
    localparam int STEP_W  = 15;
    localparam int GAIN_W  = 16;
    localparam int ACC_W   = 32;
    localparam int ERR_W   = VEL_W + 1;
    localparam int PPROD_W = GAIN_W + 1 + ERR_W;
    localparam int IPROD_W = GAIN_W + 1 + ACC_W;
    localparam int SUM_W   = IPROD_W + 1;
    localparam int CLAMP_W = 26;
    localparam int DUTY_SH = 10;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 2'd2;

    // Full scale duty in Q2.14
    localparam logic signed [VEL_W-1:0] DUTY_ONE     = 16'sd16384;
    localparam logic signed [VEL_W-1:0] DUTY_NEG_ONE = -16'sd16384;

    // Pipeline control handed from the top level to each wheel lane
    typedef struct packed {
        logic load;   // request accepted, ramp step taken
        logic adv2;   // error and accumulator stage
        logic adv3;   // multiplier stage
        logic adv4;   // duty leaves for the output register
        logic pi_en;  // at least one gain is non-zero
    } lane_ctrl_t;

endpackage

/* rtl/core/dwrpi_if.sv */
// Handshake channels for ticks, drives and register writes.
`timescale 1ns / 1ps

interface dwrpi_tick_if;
    import dwrpi_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [VEL_W-1:0] left_target_vel;
    logic signed [VEL_W-1:0] right_target_vel;
    logic signed [VEL_W-1:0] left_measured_vel;
    logic signed [VEL_W-1:0] right_measured_vel;

    modport source (output valid, left_target_vel, right_target_vel,
                    left_measured_vel, right_measured_vel, input ready);
    modport sink   (input valid, left_target_vel, right_target_vel,
                    left_measured_vel, right_measured_vel, output ready);
endinterface

interface dwrpi_drive_if;
    import dwrpi_pkg::*;
    logic                    valid;
    logic                    ready;
    logic                    pwm_mode;
    logic signed [VEL_W-1:0] left_drive;
    logic signed [VEL_W-1:0] right_drive;

    modport source (output valid, pwm_mode, left_drive, right_drive, input ready);
    modport sink   (input valid, pwm_mode, left_drive, right_drive, output ready);
endinterface

interface dwrpi_cfg_if;
    import dwrpi_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/dwrpi_lane.sv */
// One wheel: slew-rate ramp, PI accumulator, gain products and duty clamp.
`timescale 1ns / 1ps

module dwrpi_lane
    import dwrpi_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  lane_ctrl_t               ctrl,
    input  logic [STEP_W-1:0]        accel_step,
    input  logic [GAIN_W-1:0]        prop_gain,
    input  logic [GAIN_W-1:0]        integ_gain,
    input  logic signed [VEL_W-1:0]  target_vel,
    input  logic signed [VEL_W-1:0]  measured_vel,
    output logic signed [VEL_W-1:0]  drive
);

    // Wheel state
    logic signed [VEL_W-1:0]   ramped_reg, ramped_next;
    logic signed [ACC_W-1:0]   accum_reg, accum_next;
    logic signed [VEL_W-1:0]   duty_reg, duty_next;

    // Pipeline payload
    logic signed [VEL_W-1:0]   s1_ramp_reg;
    logic signed [VEL_W-1:0]   s1_meas_reg;
    logic signed [ERR_W-1:0]   s2_err_reg;
    logic                      s2_zero_reg;
    logic signed [VEL_W-1:0]   s2_ramp_reg;
    logic signed [PPROD_W-1:0] s3_pprod_reg;
    logic signed [IPROD_W-1:0] s3_iprod_reg;
    logic                      s3_zero_reg;
    logic signed [VEL_W-1:0]   s3_ramp_reg;

    logic signed [ERR_W-1:0]   delta;
    logic [ERR_W-1:0]          delta_mag;
    logic signed [ERR_W-1:0]   ramp_up;
    logic signed [ERR_W-1:0]   ramp_dn;
    logic signed [ERR_W-1:0]   err;
    logic signed [ACC_W:0]     acc_sum;
    logic                      duty_free;
    logic signed [SUM_W-1:0]   pi_sum;
    logic signed [CLAMP_W-1:0] pi_clamped;
    logic signed [VEL_W-1:0]   duty_calc;

    localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(24'sd0) + (SUM_W'(1) << 24);
    localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_MAX;

    // Move the ramped velocity toward the target by at most one step
    always_comb
    begin
        delta     = {target_vel[VEL_W-1], target_vel} - {ramped_reg[VEL_W-1], ramped_reg};
        delta_mag = delta[ERR_W-1] ? ERR_W'(-delta) : ERR_W'(delta);
        ramp_up   = {ramped_reg[VEL_W-1], ramped_reg} + $signed({2'b00, accel_step});
        ramp_dn   = {ramped_reg[VEL_W-1], ramped_reg} - $signed({2'b00, accel_step});
        if (delta_mag < {2'b00, accel_step})
            ramped_next = target_vel;
        else if (!delta[ERR_W-1] && (delta != '0))
            ramped_next = ramp_up[VEL_W-1:0];
        else
            ramped_next = ramp_dn[VEL_W-1:0];
    end

    // Error, saturating accumulator: held at full-scale duty, cleared on a zero ramp
    always_comb
    begin
        err        = {s1_ramp_reg[VEL_W-1], s1_ramp_reg}
                   - {s1_meas_reg[VEL_W-1], s1_meas_reg};
        duty_free  = (duty_reg > DUTY_NEG_ONE) && (duty_reg < DUTY_ONE);
        acc_sum    = {accum_reg[ACC_W-1], accum_reg} + (ACC_W+1)'(err);
        accum_next = accum_reg;
        if (s1_ramp_reg == '0)
            accum_next = '0;
        else if (duty_free)
        begin
            if (acc_sum[ACC_W] != acc_sum[ACC_W-1])
                accum_next = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                            : {1'b0, {(ACC_W-1){1'b1}}};
            else
                accum_next = acc_sum[ACC_W-1:0];
        end
    end

    // Sum the products, clamp to full scale and drop ten fraction bits
    always_comb
    begin
        pi_sum = (SUM_W)'(s3_pprod_reg) + (SUM_W)'(s3_iprod_reg);
        if (pi_sum > SUM_MAX)
            pi_clamped = CLAMP_W'(SUM_MAX);
        else if (pi_sum < SUM_MIN)
            pi_clamped = CLAMP_W'(SUM_MIN);
        else
            pi_clamped = pi_sum[CLAMP_W-1:0];
        duty_calc = s3_zero_reg ? '0 : pi_clamped[CLAMP_W-1:DUTY_SH];
        duty_next = duty_calc;
    end

    assign drive = ctrl.pi_en ? duty_calc : s3_ramp_reg;

    // Wheel state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ramped_reg <= '0;
            accum_reg  <= '0;
            duty_reg   <= '0;
        end
        else
        begin
            if (ctrl.load)
                ramped_reg <= ramped_next;
            if (ctrl.adv2 && ctrl.pi_en)
                accum_reg <= accum_next;
            if (ctrl.adv4 && ctrl.pi_en)
                duty_reg <= duty_next;
        end
    end

    // Pipeline payload registers
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            s1_ramp_reg <= ramped_next;
            s1_meas_reg <= measured_vel;
        end
        if (ctrl.adv2)
        begin
            s2_err_reg  <= err;
            s2_zero_reg <= (s1_ramp_reg == '0);
            s2_ramp_reg <= s1_ramp_reg;
        end
        if (ctrl.adv3)
        begin
            s3_pprod_reg <= $signed({1'b0, prop_gain}) * s2_err_reg;
            s3_iprod_reg <= $signed({1'b0, integ_gain}) * accum_reg;
            s3_zero_reg  <= s2_zero_reg;
            s3_ramp_reg  <= s2_ramp_reg;
        end
    end

endmodule

/* rtl/core/dwrpi_merge.sv */
// Output register that joins both wheel lanes into one drive request.
`timescale 1ns / 1ps

module dwrpi_merge
    import dwrpi_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    lanes_valid,
    input  logic                    pi_en,
    input  logic signed [VEL_W-1:0] left_lane,
    input  logic signed [VEL_W-1:0] right_lane,
    output logic                    take,
    dwrpi_drive_if.source           drive
);

    logic                    valid_reg;
    logic                    mode_reg;
    logic signed [VEL_W-1:0] left_reg;
    logic signed [VEL_W-1:0] right_reg;

    // Take new lane results whenever the register is empty or draining
    assign take = lanes_valid && (!valid_reg || drive.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (take)
            valid_reg <= 1'b1;
        else if (drive.ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            mode_reg  <= pi_en;
            left_reg  <= left_lane;
            right_reg <= right_lane;
        end
    end

    assign drive.valid       = valid_reg;
    assign drive.pwm_mode    = mode_reg;
    assign drive.left_drive  = left_reg;
    assign drive.right_drive = right_reg;

endmodule

/* rtl/core/dual_wheel_ramp_pi_controller.sv */
// Top level of the dual wheel ramped PI controller.
`timescale 1ns / 1ps

// Each tick request takes four stages: ramp, error and accumulate, gain
// multiply, then clamp and output register. A tick is accepted only as the
// last one leaves: the accumulator of a tick reads the duty that the previous
// tick leaves, so a tick waits until the previous one has reached the output
// register. The output register holds a finished result while the next tick
// is ramped. Register writes are taken at any time but must only be issued
// while no tick is in flight. With both gains zero the drives are the ramped
// velocities and the PI state is left untouched.

module dual_wheel_ramp_pi_controller
    import dwrpi_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    dwrpi_cfg_if.sink     cfg,
    dwrpi_tick_if.sink    tick,
    dwrpi_drive_if.source drive
);

    logic [STEP_W-1:0]       accel_step_reg;
    logic [GAIN_W-1:0]       prop_gain_reg;
    logic [GAIN_W-1:0]       integ_gain_reg;
    logic                    s1_valid_reg;
    logic                    s2_valid_reg;
    logic                    s3_valid_reg;
    logic                    take;
    lane_ctrl_t              ctrl;
    logic signed [VEL_W-1:0] left_lane;
    logic signed [VEL_W-1:0] right_lane;

    // Register writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_step_reg <= '0;
            prop_gain_reg  <= '0;
            integ_gain_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_ACCEL_STEP: accel_step_reg <= cfg.data[STEP_W-1:0];
                REG_PROP_GAIN:  prop_gain_reg  <= cfg.data[GAIN_W-1:0];
                REG_INTEG_GAIN: integ_gain_reg <= cfg.data[GAIN_W-1:0];
                default:        ;
            endcase
        end
    end

    // Admit a tick once the previous one is leaving the last stage
    assign tick.ready = !s1_valid_reg && !s2_valid_reg && (!s3_valid_reg || take);

    always_comb
    begin
        ctrl.load  = tick.valid && tick.ready;
        ctrl.adv3  = s2_valid_reg && (!s3_valid_reg || take);
        ctrl.adv2  = s1_valid_reg && (!s2_valid_reg || ctrl.adv3);
        ctrl.adv4  = take;
        ctrl.pi_en = (prop_gain_reg != '0) || (integ_gain_reg != '0);
    end

    // Stage occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.load)
                s1_valid_reg <= 1'b1;
            else if (ctrl.adv2)
                s1_valid_reg <= 1'b0;
            if (ctrl.adv2)
                s2_valid_reg <= 1'b1;
            else if (ctrl.adv3)
                s2_valid_reg <= 1'b0;
            if (ctrl.adv3)
                s3_valid_reg <= 1'b1;
            else if (take)
                s3_valid_reg <= 1'b0;
        end
    end

    dwrpi_lane u_left_lane (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .accel_step   (accel_step_reg),
        .prop_gain    (prop_gain_reg),
        .integ_gain   (integ_gain_reg),
        .target_vel   (tick.left_target_vel),
        .measured_vel (tick.left_measured_vel),
        .drive        (left_lane)
    );

    dwrpi_lane u_right_lane (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .accel_step   (accel_step_reg),
        .prop_gain    (prop_gain_reg),
        .integ_gain   (integ_gain_reg),
        .target_vel   (tick.right_target_vel),
        .measured_vel (tick.right_measured_vel),
        .drive        (right_lane)
    );

    dwrpi_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .lanes_valid (s3_valid_reg),
        .pi_en       (ctrl.pi_en),
        .left_lane   (left_lane),
        .right_lane  (right_lane),
        .take        (take),
        .drive       (drive)
    );

endmodule
